// ===== hdl/chr_pkg.sv =====
// Package: operation and status codes, scan state type for the hash ring.
`timescale 1ns / 1ps
`default_nettype none
package chr_pkg;
    localparam int RING_ENTRIES_DEF = 64;
    localparam int NODE_ID_BITS_DEF = 16;
    localparam int KEY_W = 32;
    localparam int NODE_W = 16;
    localparam int OP_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
    localparam logic [OP_W-1:0] OP_SELECT   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_VAL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_KEY  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FIX,
        S_NODE,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

// ===== hdl/chr_ram.sv =====
// Generic single-port write, single-port read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module chr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/consistent_hash_ring.sv =====
// Top level: consistent hash ring lookup table over key and node memories.
//
//  Channel | Dir | tdata fields (low bit first)                 | tuser
//  s_axis  | in  | operation[2:0], ring_key[34:3], node_id[50:35]| -
//  m_axis  | out | found[0], selected_node[16:1], status[18:17] | -
//
// Each request sweeps all RING_ENTRIES slots through the key memory read
// port, one slot a cycle; a select then also reads the node memory of the
// chosen slot. No new request is taken until the previous one is done.
// The single read port of the key memory sets the sweep rate.
// Reset clears all valid bits at once; memories are not cleared.
// A held result stalls the next request only until m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none
module consistent_hash_ring
    import chr_pkg::*;
#(
    parameter int RING_ENTRIES = RING_ENTRIES_DEF,
    parameter int NODE_ID_BITS = NODE_ID_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[2:0], ring_key[34:3], node_id[50:35], zero fill
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // found[0], selected_node[16:1], status[18:17], zero fill
    output logic [23:0]      m_axis_tdata
);
    localparam int AW = $clog2(RING_ENTRIES);

    state_t state_reg, state_next;

    // latched request
    logic [OP_W-1:0]         op_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [NODE_ID_BITS-1:0] node_reg;

    // scan pointers: rd_idx is address issued, cmp_idx is data returning
    logic [AW:0]   rd_idx_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic          cmp_vld_reg;

    logic [RING_ENTRIES-1:0] valid_reg;

    // scan results
    logic          hit_reg;      // key match
    logic [AW-1:0] hit_idx_reg;
    logic          up_reg;
    logic [AW-1:0] up_idx_reg;
    logic [KEY_W-1:0] up_key_reg;
    logic          low_reg;
    logic [AW-1:0] low_idx_reg;
    logic [KEY_W-1:0] low_key_reg;
    logic          any_reg;      // any valid or any node match

    // result holding register
    logic                    out_vld_reg;
    logic                    found_reg;
    logic [NODE_W-1:0]       sel_reg;
    logic [STATUS_W-1:0]     status_reg;

    // memories
    logic                    key_we;
    logic [AW-1:0]           key_waddr;
    logic [AW-1:0]           key_raddr;
    logic [KEY_W-1:0]        key_rdata;
    logic                    node_we;
    logic [AW-1:0]           node_raddr;
    logic [NODE_ID_BITS-1:0] node_rdata;

    logic [AW-1:0] free_idx;
    logic          free_any;

    chr_ram #(.WIDTH(KEY_W), .DEPTH(RING_ENTRIES)) u_keys (
        .aclk(aclk), .we(key_we), .waddr(key_waddr), .wdata(key_reg),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    chr_ram #(.WIDTH(NODE_ID_BITS), .DEPTH(RING_ENTRIES)) u_nodes (
        .aclk(aclk), .we(node_we), .waddr(key_waddr), .wdata(node_reg),
        .raddr(node_raddr), .rdata(node_rdata)
    );

    wire logic s_acc = s_axis_tvalid && s_axis_tready;
    wire logic m_acc = m_axis_tvalid && m_axis_tready;
    wire logic cur_v = cmp_vld_reg && valid_reg[cmp_idx_reg];
    wire logic upd_done = (state_reg == S_FIX);

    // lowest free slot: priority pick over the valid bits
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = RING_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = AW'(i);
                free_any = 1'b1;
            end
        end
    end

    // in scan, node memory follows the key address so both return together
    assign key_raddr  = rd_idx_reg[AW-1:0];
    assign node_raddr = (state_reg == S_FIX) ? (up_reg ? up_idx_reg : low_idx_reg)
                                             : rd_idx_reg[AW-1:0];
    assign key_waddr  = hit_reg ? hit_idx_reg : free_idx;
    assign key_we  = upd_done && (op_reg == OP_REGISTER) && (hit_reg || free_any);
    assign node_we = key_we;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_acc) state_next = S_SCAN;
            S_SCAN: if (rd_idx_reg == (AW+1)'(RING_ENTRIES - 1)) state_next = S_LAST;
            S_LAST: state_next = S_FIX;
            S_FIX:  state_next = (op_reg == OP_SELECT) ? S_NODE : S_DONE;
            S_NODE: state_next = S_DONE;
            S_DONE: if (!out_vld_reg || m_acc) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_axis_tready = (state_reg == S_IDLE) && (!out_vld_reg || m_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            out_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            rd_idx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (m_acc) out_vld_reg <= 1'b0;
            if (s_acc) begin
                op_reg      <= s_axis_tdata[2:0];
                key_reg     <= s_axis_tdata[34:3];
                node_reg    <= NODE_ID_BITS'(s_axis_tdata[50:35]);
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
                hit_reg <= 1'b0; up_reg <= 1'b0; low_reg <= 1'b0; any_reg <= 1'b0;
            end
            if (state_reg == S_SCAN) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            // advance compare stage one slot behind the address
            if (state_reg == S_SCAN || state_reg == S_LAST) begin
                cmp_vld_reg <= (state_reg == S_SCAN);
                cmp_idx_reg <= rd_idx_reg[AW-1:0];
            end
            if ((state_reg == S_SCAN || state_reg == S_LAST) && cur_v) begin
                if (key_rdata == key_reg) begin
                    hit_reg <= 1'b1; hit_idx_reg <= cmp_idx_reg;
                end
                if (op_reg != OP_DEL_VAL) any_reg <= 1'b1;
                if (!low_reg || key_rdata < low_key_reg) begin
                    low_reg <= 1'b1; low_idx_reg <= cmp_idx_reg; low_key_reg <= key_rdata;
                end
                if (key_rdata > key_reg && (!up_reg || key_rdata < up_key_reg)) begin
                    up_reg <= 1'b1; up_idx_reg <= cmp_idx_reg; up_key_reg <= key_rdata;
                end
            end
            // delete by value runs on the node memory in step with the scan
            if ((state_reg == S_SCAN || state_reg == S_LAST) && cur_v
                    && op_reg == OP_DEL_VAL && node_rdata == node_reg) begin
                valid_reg[cmp_idx_reg] <= 1'b0;
                any_reg <= 1'b1;
            end
            if (upd_done) begin
                found_reg  <= 1'b0;
                sel_reg    <= '0;
                status_reg <= ST_OK;
                unique case (op_reg)
                    OP_REGISTER: begin
                        if (hit_reg || free_any) valid_reg[key_waddr] <= 1'b1;
                        else status_reg <= ST_FULL;
                    end
                    OP_SELECT: begin
                        found_reg <= low_reg;
                        if (!low_reg) status_reg <= ST_ABSENT;
                    end
                    OP_DEL_VAL: begin
                        found_reg <= any_reg;
                        if (!any_reg) status_reg <= ST_ABSENT;
                    end
                    OP_DEL_KEY: begin
                        found_reg <= hit_reg;
                        if (hit_reg) valid_reg[hit_idx_reg] <= 1'b0;
                        else status_reg <= ST_ABSENT;
                    end
                    OP_CLEAR: begin
                        found_reg <= any_reg;
                        valid_reg <= '0;
                    end
                    default: ;
                endcase
                if (op_reg != OP_SELECT) out_vld_reg <= 1'b1;
            end
            if (state_reg == S_NODE) begin
                if (low_reg) sel_reg <= NODE_W'(node_rdata);
                out_vld_reg <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg && (state_reg == S_DONE || state_reg == S_IDLE);
    assign m_axis_tdata  = {5'd0, status_reg, sel_reg, found_reg};

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> state_reg == S_IDLE) else $error("request taken while busy");
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && status_reg == ST_FULL) |-> !found_reg)
        else $error("full with found");
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_consistent_hash_ring.sv =====
// Testbench for the consistent hash ring: directed table, overfill, then random requests.
`timescale 1ns / 1ps
`default_nettype none
module tb_consistent_hash_ring;
    import chr_pkg::*;

    localparam int SLOTS = RING_ENTRIES_DEF;
    localparam int RANDOM_REQS = 1530;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [NODE_W-1:0] node;
    } ring_req_t;

    typedef struct packed {
        logic                found;
        logic [NODE_W-1:0]   node;
        logic [STATUS_W-1:0] status;
    } ring_rsp_t;

    // Directed row: request plus optional hand-typed response.
    typedef struct packed {
        ring_req_t req;
        logic      typed;
        ring_rsp_t rsp;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [55:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;

    // Shadow ring state.
    logic [KEY_W-1:0]  shadow_keys [SLOTS];
    logic [NODE_W-1:0] shadow_nodes [SLOTS];
    logic              shadow_valid [SLOTS];

    ring_rsp_t         pending_rsp [$];
    int                error_count = 0;
    int                rsp_count = 0;
    int                full_hits = 0;
    longint            cycle_count = 0;
    bit                long_holdoff = 1'b0;
    int                holdoff_left = 0;

    consistent_hash_ring i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // operation, ring_key, node_id, zero fill
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // found, selected_node, status, zero fill
    );

    always #5 aclk = ~aclk;

    // Bound the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_consistent_hash_ring: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch at response %0d: %s got %0h expected %0h",
                 rsp_count, what, got, want);
    endtask

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (shadow_valid[i] && shadow_keys[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int occupancy();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            n += shadow_valid[i];
        return n;
    endfunction

    // Apply one request to the shadow ring and return the response it yields.
    function automatic ring_rsp_t ring_apply(input ring_req_t r);
        ring_rsp_t res;
        int slot;
        int up;
        int low;
        res = '0;
        case (r.op)
            OP_REGISTER: begin
                slot = find_slot(r.key);
                if (slot < 0)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!shadow_valid[i]) slot = i;
                if (slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_keys[slot] = r.key;
                    shadow_nodes[slot] = r.node;
                    shadow_valid[slot] = 1'b1;
                end
            end
            OP_SELECT: begin
                up = -1;
                low = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_valid[i]) begin
                        if (low < 0 || shadow_keys[i] < shadow_keys[low]) low = i;
                        if (shadow_keys[i] > r.key &&
                            (up < 0 || shadow_keys[i] < shadow_keys[up])) up = i;
                    end
                end
                if (up < 0) up = low;
                if (up < 0) begin
                    res.status = ST_ABSENT;
                end else begin
                    res.found = 1'b1;
                    res.node = shadow_nodes[up];
                end
            end
            OP_DEL_VAL: begin
                for (int i = 0; i < SLOTS; i++)
                    if (shadow_valid[i] && shadow_nodes[i] == r.node) begin
                        shadow_valid[i] = 1'b0;
                        res.found = 1'b1;
                    end
                if (!res.found) res.status = ST_ABSENT;
            end
            OP_DEL_KEY: begin
                slot = find_slot(r.key);
                if (slot < 0) begin
                    res.status = ST_ABSENT;
                end else begin
                    shadow_valid[slot] = 1'b0;
                    res.found = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_valid[i]) res.found = 1'b1;
                    shadow_valid[i] = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Drive one request, hold it until accepted, then predict.
    task automatic send_request(input ring_req_t r, input bit typed, input ring_rsp_t want);
        ring_rsp_t pred;
        s_axis_tdata <= {5'b0, r.node, r.key, r.op};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pred = ring_apply(r);
        if (r.op == OP_REGISTER && pred.status == ST_FULL) full_hits++;
        if (typed && pred != want)
            report_mismatch("typed row vs predictor", pred, want);
        pending_rsp.push_back(pred);
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0) @(posedge aclk);
    endtask

    // Random key: mostly from a small pool so that hits and collisions occur.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0;
            2, 3: return $urandom();
            default: return {$urandom_range(0, 3) == 0 ? $urandom() : 32'h0} ^
                            ($urandom_range(0, 95) << 24);
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] pick_node();
        return ($urandom_range(0, 3) == 0) ? NODE_W'($urandom()) : NODE_W'($urandom_range(0, 11));
    endfunction

    // Receiver: check responses, stall on its own pattern, long hold-off on demand.
    always @(posedge aclk) begin
        ring_rsp_t got;
        ring_rsp_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found  = m_axis_tdata[0];
                got.node   = m_axis_tdata[16:1];
                got.status = m_axis_tdata[18:17];
                rsp_count++;
                if (pending_rsp.size() == 0) begin
                    report_mismatch("unexpected response", got, 0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (got.found !== want.found) report_mismatch("found", got.found, want.found);
                    if (got.node !== want.node) report_mismatch("selected_node", got.node, want.node);
                    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                end
            end
            if (long_holdoff && holdoff_left == 0) begin
                holdoff_left <= 600;
                long_holdoff <= 1'b0;
                m_axis_tready <= 1'b0;
            end else if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                m_axis_tready <= (holdoff_left == 1);
            end else begin
                // alternate calm stretches and choppy ones
                m_axis_tready <= (cycle_count[11:9] < 2) ? 1'b1 : ($urandom_range(0, 2) != 0);
            end
        end
    end

    dir_row_t dir_rows [$];

    function automatic dir_row_t row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                     input logic [NODE_W-1:0] node, input bit typed,
                                     input logic found, input logic [NODE_W-1:0] sel,
                                     input logic [STATUS_W-1:0] st);
        dir_row_t d;
        d.req = '{op, key, node};
        d.typed = typed;
        d.rsp = '{found, sel, st};
        return d;
    endfunction

    initial begin
        ring_req_t r;
        int burst;
        int gap;
        for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty-table cases, extremes, every operation, unused codes, wrap.
        dir_rows.push_back(row(OP_SELECT,   32'h0,        16'h0,    1, 0, 0,        ST_ABSENT));
        dir_rows.push_back(row(OP_DEL_KEY,  32'h5,        16'h0,    1, 0, 0,        ST_ABSENT));
        dir_rows.push_back(row(OP_DEL_VAL,  32'h0,        16'h7,    1, 0, 0,        ST_ABSENT));
        dir_rows.push_back(row(OP_CLEAR,    32'h0,        16'h0,    1, 0, 0,        ST_OK));
        dir_rows.push_back(row(OP_REGISTER, 32'h0,        16'hFFFF, 1, 0, 0,        ST_OK));
        dir_rows.push_back(row(OP_REGISTER, 32'hFFFFFFFF, 16'h0001, 1, 0, 0,        ST_OK));
        dir_rows.push_back(row(OP_REGISTER, 32'h8000_0000, 16'h1234, 1, 0, 0,       ST_OK));
        dir_rows.push_back(row(OP_SELECT,   32'h0,        16'h0,    1, 1, 16'h1234, ST_OK));
        dir_rows.push_back(row(OP_SELECT,   32'hFFFFFFFF, 16'h0,    1, 1, 16'hFFFF, ST_OK));
        dir_rows.push_back(row(OP_SELECT,   32'h8000_0000, 16'h0,   1, 1, 16'h0001, ST_OK));
        dir_rows.push_back(row(OP_REGISTER, 32'h8000_0000, 16'hAAAA, 1, 0, 0,       ST_OK));
        dir_rows.push_back(row(OP_SELECT,   32'h7FFF_FFFF, 16'h0,   0, 0, 0,        ST_OK));
        dir_rows.push_back(row(3'd5,        32'hFFFFFFFF, 16'hFFFF, 1, 0, 0,        ST_OK));
        dir_rows.push_back(row(3'd6,        32'h0,        16'h0,    1, 0, 0,        ST_OK));
        dir_rows.push_back(row(3'd7,        32'h5555_5555, 16'h5555, 1, 0, 0,       ST_OK));
        dir_rows.push_back(row(OP_DEL_VAL,  32'h0,        16'hFFFF, 1, 1, 0,        ST_OK));
        dir_rows.push_back(row(OP_DEL_KEY,  32'hFFFFFFFF, 16'h0,    1, 1, 0,        ST_OK));
        dir_rows.push_back(row(OP_DEL_KEY,  32'hFFFFFFFF, 16'h0,    1, 0, 0,        ST_ABSENT));
        dir_rows.push_back(row(OP_CLEAR,    32'h0,        16'h0,    1, 1, 0,        ST_OK));
        dir_rows.push_back(row(OP_CLEAR,    32'h0,        16'h0,    1, 0, 0,        ST_OK));
        foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        drop_valid();
        wait_drained();

        // Fill the ring past capacity; the receiver starts a long hold-off.
        long_holdoff = 1'b1;
        for (int i = 0; i < SLOTS + 3; i++) begin
            r = '{OP_REGISTER, $urandom(), NODE_W'($urandom_range(0, 7))};
            send_request(r, 0, '0);
        end
        r = '{OP_SELECT, $urandom(), '0};
        send_request(r, 0, '0);
        drop_valid();
        wait_drained();

        // Random bursts; occasional clears of a ring holding over 40 entries let it both fill and drain.
        for (int n = 0; n < RANDOM_REQS; ) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++, n++) begin
                r.key = pick_key();
                r.node = pick_node();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7: r.op = OP_REGISTER;
                    8, 9, 10, 11, 12, 13: r.op = OP_SELECT;
                    14, 15: r.op = OP_DEL_KEY;
                    16: r.op = OP_DEL_VAL;
                    17: r.op = (occupancy() > 40 && n % 3 == 0) ? OP_CLEAR : OP_SELECT;
                    18: r.op = ($urandom_range(0, 3) == 0) ? OP_W'($urandom_range(5, 7)) : OP_DEL_KEY;
                    default: r.op = OP_REGISTER;
                endcase
                // reuse a live key now and then so hits are common
                if ($urandom_range(0, 2) == 0)
                    for (int i = 0; i < SLOTS; i++)
                        if (shadow_valid[i] && $urandom_range(0, 7) == 0) r.key = shadow_keys[i];
                send_request(r, 0, '0);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            if (n % 400 < burst) long_holdoff = 1'b1;
        end
        drop_valid();
        wait_drained();
        repeat (150) @(posedge aclk);

        $display("covered %0d responses, %0d table-full rejects, final occupancy %0d",
                 rsp_count, full_hits, occupancy());
        $display("all five operations, unused codes, wrap-around select and stall phases run");
        if (error_count == 0) begin
            $display("tb_consistent_hash_ring: clean");
        end else begin
            $display("tb_consistent_hash_ring: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
